### hdl/vfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfa_pkg
// types, constants and helpers shared by the vector fixed-point alu pipeline
// ----------------------------------------------------------------------------
package vfa_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DIV_W      = 32 + FRAC_BITS;
  localparam int SQ_STAGES  = 32;

  typedef enum logic [3:0] {
    OP_SCALE     = 4'd0,
    OP_DIVIDE    = 4'd1,
    OP_ADD       = 4'd2,
    OP_SUB       = 4'd3,
    OP_NEGATE    = 4'd4,
    OP_DOT       = 4'd5,
    OP_CROSS     = 4'd6,
    OP_LENGTH    = 4'd7,
    OP_LENSQ     = 4'd8,
    OP_NORMALIZE = 4'd9
  } op_e;

  typedef struct packed {
    logic [3:0]         operation;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scalar_in;
  } vfa_req_t;

  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic signed [31:0] res_scalar;
    logic               saturated;
    logic               error;
  } vfa_rsp_t;

  // operation state handed down the pipeline
  typedef struct packed {
    logic [3:0]                 op;
    vfa_rsp_t                   rsp;
    logic [2:0]                 neg;
    logic [2:0][DIV_W-1:0]      num;
    logic [31:0]                dvs;
    logic [31:0]                root;
  } vfa_carry_t;

  // saturate a wide signed value, msb of result is the clip flag
  function automatic logic [32:0] clip66(input logic signed [65:0] v);
    if (v[65:31] == {35{v[65]}}) begin
      return {1'b0, v[31:0]};
    end else if (v[65]) begin
      return {1'b1, 32'h8000_0000};
    end else begin
      return {1'b1, 32'h7fff_ffff};
    end
  endfunction

  // signed, saturated result from an unsigned quotient
  function automatic logic [32:0] sign_quot(input logic [DIV_W-1:0] q, input logic neg);
    logic [DIV_W-1:0] lim;
    lim = {{(DIV_W-32){1'b0}}, 32'h8000_0000};
    if (neg) begin
      if (q > lim) begin
        return {1'b1, 32'h8000_0000};
      end else begin
        return {1'b0, 32'(-q[31:0])};
      end
    end else begin
      if (q >= lim) begin
        return {1'b1, 32'h7fff_ffff};
      end else begin
        return {1'b0, q[31:0]};
      end
    end
  endfunction

endpackage
`default_nettype wire

### hdl/vfa_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfa_front
// three stages: products, sums, then shift, saturation and divide setup
// ----------------------------------------------------------------------------
module vfa_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  vfa_pkg::vfa_req_t   req_i,
  output logic                valid_o,
  output vfa_pkg::vfa_carry_t carry_o,
  output logic [63:0]         ssq_o
);
  import vfa_pkg::*;

  // stage 1
  logic               v1_q;
  logic [3:0]         op1_q;
  logic signed [31:0] a1_q [3];
  logic signed [31:0] b1_q [3];
  logic signed [31:0] s1_q;
  logic signed [63:0] pas_q [3];
  logic signed [63:0] pab_q [3];
  logic signed [63:0] pcr_q [6];
  logic signed [63:0] psq_q [3];

  // stage 2
  logic               v2_q;
  logic [3:0]         op2_q;
  logic signed [65:0] wide2_q [3];
  logic signed [65:0] dot2_q;
  logic [63:0]        ssq2_q;
  logic [2:0][DIV_W-1:0] num2_q;
  logic [2:0]         neg2_q;
  logic [31:0]        dvs2_q;
  logic               szero2_q;

  // stage 3
  logic               v3_q;
  vfa_carry_t         carry3_q;
  logic [63:0]        ssq3_q;

  logic signed [65:0] wide_d [3];
  logic [2:0][DIV_W-1:0] num_d;
  logic [2:0]         neg_d;
  logic [31:0]        mag_d [3];
  vfa_carry_t         carry_d;
  logic [32:0]        cl_d [3];
  logic [32:0]        cls_d;
  logic [63:0]        lsq_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q    <= req_i.operation;
      a1_q[0]  <= req_i.a_x;
      a1_q[1]  <= req_i.a_y;
      a1_q[2]  <= req_i.a_z;
      b1_q[0]  <= req_i.b_x;
      b1_q[1]  <= req_i.b_y;
      b1_q[2]  <= req_i.b_z;
      s1_q     <= req_i.scalar_in;
      pas_q[0] <= $signed(req_i.a_x) * $signed(req_i.scalar_in);
      pas_q[1] <= $signed(req_i.a_y) * $signed(req_i.scalar_in);
      pas_q[2] <= $signed(req_i.a_z) * $signed(req_i.scalar_in);
      pab_q[0] <= $signed(req_i.a_x) * $signed(req_i.b_x);
      pab_q[1] <= $signed(req_i.a_y) * $signed(req_i.b_y);
      pab_q[2] <= $signed(req_i.a_z) * $signed(req_i.b_z);
      pcr_q[0] <= $signed(req_i.a_y) * $signed(req_i.b_z);
      pcr_q[1] <= $signed(req_i.b_y) * $signed(req_i.a_z);
      pcr_q[2] <= $signed(req_i.a_z) * $signed(req_i.b_x);
      pcr_q[3] <= $signed(req_i.b_z) * $signed(req_i.a_x);
      pcr_q[4] <= $signed(req_i.a_x) * $signed(req_i.b_y);
      pcr_q[5] <= $signed(req_i.b_x) * $signed(req_i.a_y);
      psq_q[0] <= $signed(req_i.a_x) * $signed(req_i.a_x);
      psq_q[1] <= $signed(req_i.a_y) * $signed(req_i.a_y);
      psq_q[2] <= $signed(req_i.a_z) * $signed(req_i.a_z);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = a1_q[i][31] ? 32'(-a1_q[i]) : 32'(a1_q[i]);
      num_d[i] = {mag_d[i], {FRAC_BITS{1'b0}}};
      neg_d[i] = a1_q[i][31] ^ ((op1_q == OP_DIVIDE) & s1_q[31]);
      case (op1_q)
        OP_SCALE:  wide_d[i] = {{2{pas_q[i][63]}}, pas_q[i]};
        OP_CROSS:  wide_d[i] = $signed({{2{pcr_q[2*i][63]}}, pcr_q[2*i]})
                             - $signed({{2{pcr_q[2*i+1][63]}}, pcr_q[2*i+1]});
        OP_ADD:    wide_d[i] = $signed({{34{a1_q[i][31]}}, a1_q[i]})
                             + $signed({{34{b1_q[i][31]}}, b1_q[i]});
        OP_SUB:    wide_d[i] = $signed({{34{a1_q[i][31]}}, a1_q[i]})
                             - $signed({{34{b1_q[i][31]}}, b1_q[i]});
        OP_NEGATE: wide_d[i] = -$signed({{34{a1_q[i][31]}}, a1_q[i]});
        default:   wide_d[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op2_q      <= op1_q;
      wide2_q[0] <= wide_d[0];
      wide2_q[1] <= wide_d[1];
      wide2_q[2] <= wide_d[2];
      dot2_q     <= $signed({{2{pab_q[0][63]}}, pab_q[0]})
                  + $signed({{2{pab_q[1][63]}}, pab_q[1]})
                  + $signed({{2{pab_q[2][63]}}, pab_q[2]});
      ssq2_q     <= 64'(psq_q[0]) + 64'(psq_q[1]) + 64'(psq_q[2]);
      num2_q     <= num_d;
      neg2_q     <= neg_d;
      dvs2_q     <= s1_q[31] ? 32'(-s1_q) : 32'(s1_q);
      szero2_q   <= (s1_q == '0);
    end
  end

  always_comb begin
    carry_d      = '0;
    carry_d.op   = op2_q;
    carry_d.neg  = neg2_q;
    carry_d.num  = num2_q;
    carry_d.dvs  = dvs2_q;
    lsq_d        = ssq2_q >> FRAC_BITS;
    cls_d        = clip66(dot2_q >>> FRAC_BITS);
    for (int i = 0; i < 3; i++) begin
      if (op2_q == OP_SCALE || op2_q == OP_CROSS) begin
        cl_d[i] = clip66(wide2_q[i] >>> FRAC_BITS);
      end else begin
        cl_d[i] = clip66(wide2_q[i]);
      end
    end
    case (op2_q)
      OP_SCALE, OP_CROSS, OP_ADD, OP_SUB, OP_NEGATE: begin
        carry_d.rsp.res_x     = cl_d[0][31:0];
        carry_d.rsp.res_y     = cl_d[1][31:0];
        carry_d.rsp.res_z     = cl_d[2][31:0];
        carry_d.rsp.saturated = cl_d[0][32] | cl_d[1][32] | cl_d[2][32];
      end
      OP_DOT: begin
        carry_d.rsp.res_scalar = cls_d[31:0];
        carry_d.rsp.saturated  = cls_d[32];
      end
      OP_LENSQ: begin
        if (lsq_d[63:31] != '0) begin
          carry_d.rsp.res_scalar = 32'h7fff_ffff;
          carry_d.rsp.saturated  = 1'b1;
        end else begin
          carry_d.rsp.res_scalar = lsq_d[31:0];
        end
      end
      OP_DIVIDE: begin
        carry_d.rsp.error = szero2_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      carry3_q <= carry_d;
      ssq3_q   <= ssq2_q;
    end
  end

  assign valid_o = v3_q;
  assign carry_o = carry3_q;
  assign ssq_o   = ssq3_q;

endmodule
`default_nettype wire

### hdl/vfa_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfa_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module vfa_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  vfa_pkg::vfa_carry_t carry_i,
  input  logic [63:0]         ssq_i,
  output logic                valid_o,
  output vfa_pkg::vfa_carry_t carry_o
);
  import vfa_pkg::*;

  logic        v_q   [SQ_STAGES+1];
  vfa_carry_t  c_q   [SQ_STAGES+1];
  logic [63:0] rem_q [SQ_STAGES+1];
  logic [63:0] rt_q  [SQ_STAGES+1];

  assign v_q[0]   = valid_i;
  assign c_q[0]   = carry_i;
  assign rem_q[0] = ssq_i;
  assign rt_q[0]  = '0;

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = rt_q[k] + Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        c_q[k+1] <= c_q[k];
        if (rem_q[k] >= trial) begin
          rem_q[k+1] <= rem_q[k] - trial;
          rt_q[k+1]  <= (rt_q[k] >> 1) + Bit;
        end else begin
          rem_q[k+1] <= rem_q[k];
          rt_q[k+1]  <= rt_q[k] >> 1;
        end
      end
    end
  end

  always_comb begin
    carry_o      = c_q[SQ_STAGES];
    carry_o.root = rt_q[SQ_STAGES][31:0];
  end
  assign valid_o = v_q[SQ_STAGES];

endmodule
`default_nettype wire

### hdl/vfa_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfa_div
// pipelined three-lane restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module vfa_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  vfa_pkg::vfa_carry_t     carry_i,
  output logic                    valid_o,
  output vfa_pkg::vfa_carry_t     carry_o,
  output logic [2:0][vfa_pkg::DIV_W-1:0] quot_o
);
  import vfa_pkg::*;

  logic                  v_q  [DIV_W+1];
  vfa_carry_t            c_q  [DIV_W+1];
  logic [2:0][31:0]      rm_q [DIV_W+1];
  logic [2:0][DIV_W-1:0] nq_q [DIV_W+1];

  always_comb begin
    c_q[0]     = carry_i;
    c_q[0].dvs = (carry_i.op == OP_DIVIDE) ? carry_i.dvs : carry_i.root;
  end
  assign v_q[0]  = valid_i;
  assign rm_q[0] = '0;
  assign nq_q[0] = carry_i.num;

  for (genvar j = 0; j < DIV_W; j++) begin : g_stage
    logic [2:0][32:0] trial;
    logic [2:0]       ge;
    logic [2:0][32:0] diff;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        trial[l] = {rm_q[j][l], nq_q[j][l][DIV_W-1]};
        ge[l]    = trial[l] >= {1'b0, c_q[j].dvs};
        diff[l]  = trial[l] - {1'b0, c_q[j].dvs};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        c_q[j+1] <= c_q[j];
        for (int l = 0; l < 3; l++) begin
          rm_q[j+1][l] <= ge[l] ? diff[l][31:0] : trial[l][31:0];
          nq_q[j+1][l] <= {nq_q[j][l][DIV_W-2:0], ge[l]};
        end
      end
    end
  end

  assign valid_o = v_q[DIV_W];
  assign carry_o = c_q[DIV_W];
  assign quot_o  = nq_q[DIV_W];

endmodule
`default_nettype wire

### hdl/vector3_fixed_point_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu
// pipelined q16.16 three-component vector alu with saturating results
// ----------------------------------------------------------------------------
// One request enters per clock while the result side does not stall, and each
// result passes, whatever the operation, through the same pipeline:
// three stages of products and sums, a 32-stage square root, a divider that
// takes one stage per quotient bit and an output register. A stall on the
// result side holds the whole pipeline, so ready follows the output register.
module vector3_fixed_point_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  vfa_pkg::vfa_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output vfa_pkg::vfa_rsp_t rsp_o
);
  import vfa_pkg::*;

  logic                  en;
  logic                  f_valid;
  vfa_carry_t            f_carry;
  logic [63:0]           f_ssq;
  logic                  s_valid;
  vfa_carry_t            s_carry;
  logic                  d_valid;
  vfa_carry_t            d_carry;
  logic [2:0][DIV_W-1:0] d_quot;
  vfa_rsp_t              rsp_d;
  logic [32:0]           lane [3];
  logic                  do_div;
  logic                  rsp_valid_q;
  vfa_rsp_t              rsp_q;

  assign en          = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = en;

  vfa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (req_valid_i),
    .req_i   (req_i),
    .valid_o (f_valid),
    .carry_o (f_carry),
    .ssq_o   (f_ssq)
  );

  vfa_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .carry_i (f_carry),
    .ssq_i   (f_ssq),
    .valid_o (s_valid),
    .carry_o (s_carry)
  );

  vfa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_valid),
    .carry_i (s_carry),
    .valid_o (d_valid),
    .carry_o (d_carry),
    .quot_o  (d_quot)
  );

  always_comb begin
    rsp_d  = d_carry.rsp;
    do_div = ((d_carry.op == OP_DIVIDE) && !d_carry.rsp.error)
          || ((d_carry.op == OP_NORMALIZE) && (d_carry.root != '0));
    for (int i = 0; i < 3; i++) begin
      lane[i] = sign_quot(d_quot[i], d_carry.neg[i]);
    end
    if (do_div) begin
      rsp_d.res_x     = lane[0][31:0];
      rsp_d.res_y     = lane[1][31:0];
      rsp_d.res_z     = lane[2][31:0];
      rsp_d.saturated = lane[0][32] | lane[1][32] | lane[2][32];
    end
    if ((d_carry.op == OP_NORMALIZE) && (d_carry.root == '0)) begin
      rsp_d.error = 1'b1;
    end
    if (d_carry.op == OP_LENGTH) begin
      if (d_carry.root[31]) begin
        rsp_d.res_scalar = 32'h7fff_ffff;
        rsp_d.saturated  = 1'b1;
      end else begin
        rsp_d.res_scalar = d_carry.root;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (en) begin
      rsp_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
`default_nettype wire
